### hdl/u8cjk_pkg.sv
// shared types, constants and range test for the utf-8 cjk bigram extractor
// no dependencies
package u8cjk_pkg;

   localparam int CpWidth   = 21;
   localparam int CharWidth = 16;

   // lead byte classes
   localparam logic [7:0] AsciiLimit   = 8'h80;
   localparam logic [7:0] Lead2Mask    = 8'hE0;
   localparam logic [7:0] Lead2Code    = 8'hC0;
   localparam logic [7:0] Lead3Mask    = 8'hF0;
   localparam logic [7:0] Lead3Code    = 8'hE0;
   localparam logic [7:0] Lead4Mask    = 8'hF8;
   localparam logic [7:0] Lead4Code    = 8'hF0;
   localparam logic [7:0] FollowMask   = 8'h3F;

   // follow byte counts
   localparam logic [1:0] NeedNone  = 2'd0;
   localparam logic [1:0] NeedOne   = 2'd1;
   localparam logic [1:0] NeedTwo   = 2'd2;
   localparam logic [1:0] NeedThree = 2'd3;

   // cjk ideograph ranges
   localparam logic [CpWidth-1:0] ExtALow  = 21'h003400;
   localparam logic [CpWidth-1:0] ExtAHigh = 21'h004DBF;
   localparam logic [CpWidth-1:0] UniLow   = 21'h004E00;
   localparam logic [CpWidth-1:0] UniHigh  = 21'h009FFF;
   localparam logic [CpWidth-1:0] CompLow  = 21'h00F900;
   localparam logic [CpWidth-1:0] CompHigh = 21'h00FAFF;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_payload_type;

   typedef struct packed {
      logic                 pair_valid;
      logic [CharWidth-1:0] first_char;
      logic [CharWidth-1:0] second_char;
      logic                 end_of_name;
   } rsp_payload_type;

   typedef struct packed {
      logic [CpWidth-1:0]   partial_code_point;
      logic [1:0]           bytes_still_needed;
      logic [CharWidth-1:0] previous_cjk_char;
      logic                 previous_is_cjk;
   } dec_state_type;

   function automatic logic in_cjk_range(input logic [CpWidth-1:0] cp);
      in_cjk_range = (cp >= ExtALow && cp <= ExtAHigh) ||
                     (cp >= UniLow  && cp <= UniHigh)  ||
                     (cp >= CompLow && cp <= CompHigh);
   endfunction

endpackage

### hdl/utf8_cjk_bigram_extractor_core.sv
// a result item appears in the cycle after its byte is accepted
// throughput: one byte per cycle unless the result stalls, set by the single
// decode step between the decoder state register and the result register
// a new item is taken while the held result is being taken (rsp_ready high)
// reset clears the decoder state and the result valid flag; no clearing pass
// depends on u8cjk_pkg and u8cjk_decode
module utf8_cjk_bigram_extractor_core
   import u8cjk_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_payload
);

   dec_state_type   state_ff;
   dec_state_type   state_in;
   rsp_payload_type rsp_payload_ff;
   rsp_payload_type rsp_payload_in;
   logic            rsp_valid_ff;
   logic            accept;

   // result register free or being emptied this cycle
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   u8cjk_decode u_decode (
      .state      (state_ff),
      .req        (req_payload),
      .state_next (state_in),
      .rsp        (rsp_payload_in)
   );

   // decoder state and result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            state_ff <= state_in;
         end
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

### hdl/u8cjk_decode.sv
// per-byte utf-8 decode step and cjk run tracking, purely combinational
// depends on u8cjk_pkg
module u8cjk_decode
   import u8cjk_pkg::*;
(
   input  dec_state_type   state,
   input  req_payload_type req,
   output dec_state_type   state_next,
   output rsp_payload_type rsp
);

   logic               done;
   logic [CpWidth-1:0] cp;
   logic [CpWidth-1:0] gathered;
   logic [7:0]         b;

   assign b        = req.data_byte;
   // append six low bits of a follow byte
   assign gathered = {state.partial_code_point[CpWidth-7:0], b[5:0] & FollowMask[5:0]};

   always_comb begin
      done       = 1'b0;
      cp         = '0;
      state_next = state;
      rsp        = '0;

      // byte classification
      priority if (state.bytes_still_needed != NeedNone) begin
         state_next.partial_code_point = gathered;
         state_next.bytes_still_needed = state.bytes_still_needed - NeedOne;
         if (state.bytes_still_needed == NeedOne) begin
            cp   = gathered;
            done = 1'b1;
         end
      end else if (b < AsciiLimit) begin
         cp   = {{(CpWidth-8){1'b0}}, b};
         done = 1'b1;
      end else if ((b & Lead2Mask) == Lead2Code) begin
         state_next.partial_code_point = {{(CpWidth-5){1'b0}}, b[4:0]};
         state_next.bytes_still_needed = NeedOne;
      end else if ((b & Lead3Mask) == Lead3Code) begin
         state_next.partial_code_point = {{(CpWidth-4){1'b0}}, b[3:0]};
         state_next.bytes_still_needed = NeedTwo;
      end else if ((b & Lead4Mask) == Lead4Code) begin
         state_next.partial_code_point = {{(CpWidth-3){1'b0}}, b[2:0]};
         state_next.bytes_still_needed = NeedThree;
      end else begin
         // stray byte decodes as zero
         cp   = '0;
         done = 1'b1;
      end

      // bigram formation on a completed code point
      if (done) begin
         state_next.partial_code_point = '0;
         if (in_cjk_range(cp)) begin
            if (state.previous_is_cjk) begin
               rsp.pair_valid  = 1'b1;
               rsp.first_char  = state.previous_cjk_char;
               rsp.second_char = cp[CharWidth-1:0];
            end
            state_next.previous_cjk_char = cp[CharWidth-1:0];
            state_next.previous_is_cjk   = 1'b1;
         end else begin
            state_next.previous_cjk_char = '0;
            state_next.previous_is_cjk   = 1'b0;
         end
      end

      // end of name clears everything
      rsp.end_of_name = req.last_byte;
      if (req.last_byte) begin
         state_next = '0;
      end
   end

endmodule

### hdl/u8cjk_checker.sv
// port-level checks for the utf-8 cjk bigram extractor, bound to the top level
// depends on u8cjk_pkg and utf8_cjk_bigram_extractor_core
module u8cjk_checker
   import u8cjk_pkg::*;
(
   input logic            clock,
   input logic            reset,
   input logic            req_valid,
   input logic            req_ready,
   input req_payload_type req_payload,
   input logic            rsp_valid,
   input logic            rsp_ready,
   input rsp_payload_type rsp_payload
);

   // every accepted item gives a result item in the next cycle
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("no result after accepted item");

   // end of name is carried through to the result
   a_end_echo: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_payload.last_byte |=> rsp_payload.end_of_name)
      else $error("end of name lost");

   // characters are zero when no pair is reported
   a_zero_no_pair: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.pair_valid |->
         rsp_payload.first_char == '0 && rsp_payload.second_char == '0)
      else $error("characters set without a pair");

   // both characters of a pair are cjk ideographs
   a_pair_cjk: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.pair_valid |->
         in_cjk_range({5'b0, rsp_payload.first_char}) &&
         in_cjk_range({5'b0, rsp_payload.second_char}))
      else $error("pair holds a non-cjk character");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled result changed");

endmodule

bind utf8_cjk_bigram_extractor_core u8cjk_checker u_checker (.*);

### tb/testbench.sv
// self-checking testbench for utf8_cjk_bigram_extractor_core: directed table then random names
// depends on u8cjk_pkg (payload types, lead byte constants) and the core itself
module testbench;
   import u8cjk_pkg::*;

   localparam int CycleLimit = 200000;
   localparam int RandomBytes = 1900;

   localparam rsp_payload_type NoPair    = '0;
   localparam rsp_payload_type NoPairEnd = {1'b0, 16'h0000, 16'h0000, 1'b1};

   typedef struct packed {
      logic [7:0]      data_byte;
      logic            last_byte;
      logic            has_want;
      rsp_payload_type want;
   } dir_row_type;

   typedef enum logic [1:0] {ReadyAlways, ReadyRandom, ReadyPattern} ready_mode_type;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_ready;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_ready = 1'b0;
   rsp_payload_type rsp_payload;

   // predictor state
   logic [CpWidth-1:0]   acc_cp = '0;
   logic [1:0]           owed = NeedNone;
   logic [CharWidth-1:0] prev_char = '0;
   logic                 prev_cjk = 1'b0;

   rsp_payload_type expected_bigrams [$];
   rsp_payload_type want_rsp;
   int              mismatch_count = 0;
   int              bytes_sent = 0;
   int              burst_left = 0;
   int              cycle_count = 0;
   ready_mode_type  ready_mode = ReadyAlways;
   logic [7:0]      ready_mask = 8'hFF;
   int              ready_left = 0;

   // code points either side of each ideograph range
   logic [CpWidth-1:0] range_edges [12] = '{
      21'h33FF, 21'h3400, 21'h4DBF, 21'h4DC0, 21'h4DFF, 21'h4E00,
      21'h9FFF, 21'hA000, 21'hF8FF, 21'hF900, 21'hFAFF, 21'hFB00};

   // directed items: extremes, every lead class, stray bytes, cut-off sequences
   dir_row_type dir_table [25] = '{
      {8'h00, 1'b0, 1'b1, NoPair},
      {8'h7F, 1'b0, 1'b1, NoPair},
      {8'hE4, 1'b0, 1'b0, NoPair},
      {8'hB8, 1'b0, 1'b0, NoPair},
      {8'h80, 1'b0, 1'b0, NoPair},
      {8'hE9, 1'b0, 1'b0, NoPair},
      {8'hBF, 1'b0, 1'b0, NoPair},
      {8'hBF, 1'b0, 1'b1, {1'b1, 16'h4E00, 16'h9FFF, 1'b0}},
      {8'hFF, 1'b0, 1'b1, NoPair},
      {8'hEF, 1'b0, 1'b0, NoPair},
      {8'hA4, 1'b0, 1'b0, NoPair},
      {8'h80, 1'b0, 1'b0, NoPair},
      {8'hE3, 1'b0, 1'b0, NoPair},
      {8'h90, 1'b0, 1'b0, NoPair},
      {8'h80, 1'b0, 1'b1, {1'b1, 16'hF900, 16'h3400, 1'b0}},
      {8'hC2, 1'b0, 1'b0, NoPair},
      {8'h41, 1'b0, 1'b0, NoPair},
      {8'hF0, 1'b0, 1'b0, NoPair},
      {8'h90, 1'b0, 1'b0, NoPair},
      {8'h80, 1'b0, 1'b0, NoPair},
      {8'h80, 1'b0, 1'b0, NoPair},
      {8'hE4, 1'b1, 1'b1, NoPairEnd},
      {8'hE4, 1'b0, 1'b0, NoPair},
      {8'hB8, 1'b1, 1'b1, NoPairEnd},
      {8'h80, 1'b1, 1'b1, NoPairEnd}};

   utf8_cjk_bigram_extractor_core u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   always #5 clock = ~clock;

   // decode one byte and work out the bigram it completes, if any
   function automatic rsp_payload_type predict_bigram(input req_payload_type item);
      rsp_payload_type    res;
      logic [CpWidth-1:0] cp;
      logic               done;
      res  = '0;
      cp   = '0;
      done = 1'b0;
      if (owed != NeedNone) begin
         acc_cp = {acc_cp[CpWidth-7:0], item.data_byte[5:0]};
         owed   = owed - NeedOne;
         if (owed == NeedNone) begin
            cp   = acc_cp;
            done = 1'b1;
         end
      end else if (item.data_byte < AsciiLimit) begin
         cp   = {{(CpWidth-8){1'b0}}, item.data_byte};
         done = 1'b1;
      end else if ((item.data_byte & Lead2Mask) == Lead2Code) begin
         acc_cp = {{(CpWidth-5){1'b0}}, item.data_byte[4:0]};
         owed   = NeedOne;
      end else if ((item.data_byte & Lead3Mask) == Lead3Code) begin
         acc_cp = {{(CpWidth-4){1'b0}}, item.data_byte[3:0]};
         owed   = NeedTwo;
      end else if ((item.data_byte & Lead4Mask) == Lead4Code) begin
         acc_cp = {{(CpWidth-3){1'b0}}, item.data_byte[2:0]};
         owed   = NeedThree;
      end else begin
         done = 1'b1;
      end
      // range test and run tracking on a completed code point
      if (done) begin
         acc_cp = '0;
         if ((cp >= 21'h3400 && cp <= 21'h4DBF) || (cp >= 21'h4E00 && cp <= 21'h9FFF) ||
             (cp >= 21'hF900 && cp <= 21'hFAFF)) begin
            if (prev_cjk) begin
               res.pair_valid  = 1'b1;
               res.first_char  = prev_char;
               res.second_char = cp[CharWidth-1:0];
            end
            prev_char = cp[CharWidth-1:0];
            prev_cjk  = 1'b1;
         end else begin
            prev_char = '0;
            prev_cjk  = 1'b0;
         end
      end
      res.end_of_name = item.last_byte;
      // end of name clears everything
      if (item.last_byte) begin
         acc_cp    = '0;
         owed      = NeedNone;
         prev_char = '0;
         prev_cjk  = 1'b0;
      end
      return res;
   endfunction

   // present one item, in bursts with random gaps, and queue its expectation
   task automatic send_item(input logic [7:0] data, input logic last, input logic has_want,
                            input rsp_payload_type want);
      int              gap;
      rsp_payload_type predicted;
      if (burst_left == 0) begin
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         burst_left = $urandom_range(1, 24);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_valid   <= 1'b1;
      req_payload <= {data, last};
      do @(posedge clock); while (!req_ready);
      predicted = predict_bigram({data, last});
      expected_bigrams.insert(expected_bigrams.size(), has_want ? want : predicted);
      bytes_sent++;
      burst_left--;
   endtask

   // receiver stalls: always ready, random, or a repeating mask
   always @(posedge clock) begin
      if (ready_left == 0) begin
         ready_mode <= ready_mode_type'($urandom_range(0, 2));
         ready_mask <= 8'($urandom);
         ready_left <= $urandom_range(16, 96);
      end else begin
         ready_left <= ready_left - 1;
      end
      case (ready_mode)
         ReadyAlways: rsp_ready <= 1'b1;
         ReadyRandom: rsp_ready <= ($urandom_range(0, 9) < 6);
         default:     rsp_ready <= ready_mask[cycle_count[2:0]];
      endcase
   end

   // compare each result item with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_bigrams.size() == 0) begin
            $display("%0t: result item with nothing expected, actual %h", $time, rsp_payload);
            mismatch_count++;
         end else begin
            want_rsp = expected_bigrams.pop_front();
            if (rsp_payload.pair_valid !== want_rsp.pair_valid ||
                rsp_payload.first_char !== want_rsp.first_char ||
                rsp_payload.second_char !== want_rsp.second_char ||
                rsp_payload.end_of_name !== want_rsp.end_of_name) begin
               $display("%0t: expected pair %b %h %h end %b, actual pair %b %h %h end %b",
                        $time, want_rsp.pair_valid, want_rsp.first_char,
                        want_rsp.second_char, want_rsp.end_of_name,
                        rsp_payload.pair_valid, rsp_payload.first_char,
                        rsp_payload.second_char, rsp_payload.end_of_name);
               mismatch_count++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("utf8_cjk_bigram_extractor_core: mismatch");
         $finish;
      end
   end

   initial begin
      logic [7:0]         name_bytes [$];
      logic [CpWidth-1:0] cp;
      int                 n_chars;
      int                 pick;
      int                 len;
      logic               cut;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed table
      foreach (dir_table[i])
         send_item(dir_table[i].data_byte, dir_table[i].last_byte, dir_table[i].has_want,
                   dir_table[i].want);

      // random names, mostly well-formed runs of ideographs
      while (bytes_sent < RandomBytes) begin
         name_bytes.delete();
         n_chars = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
         for (int c = 0; c < n_chars; c++) begin
            pick = $urandom_range(0, 99);
            cut  = 1'b0;
            if (pick < 30) cp = 21'($urandom_range(21'h4E00, 21'h9FFF));
            else if (pick < 40) cp = 21'($urandom_range(21'h3400, 21'h4DBF));
            else if (pick < 48) cp = 21'($urandom_range(21'hF900, 21'hFAFF));
            else if (pick < 58) cp = range_edges[$urandom_range(0, 11)];
            else if (pick < 70) cp = 21'($urandom_range(0, 127));
            else if (pick < 78) cp = 21'($urandom_range(0, 21'h1FFFFF));
            else if (pick < 90) begin
               cp   = 21'($urandom_range(21'h4E00, 21'h9FFF));
               cut  = 1'b1;
            end
            if (pick >= 90) begin
               // noise byte of any value
               name_bytes.insert(name_bytes.size(), 8'($urandom_range(0, 255)));
            end else begin
               len = (cp < 21'h80) ? 1 : (cp < 21'h800) ? 2 : (cp < 21'h10000) ? 3 : 4;
               // occasional overlong form
               if (len < 4 && $urandom_range(0, 9) == 0) len++;
               case (len)
                  1: name_bytes.insert(name_bytes.size(), {1'b0, cp[6:0]});
                  2: begin
                     name_bytes.insert(name_bytes.size(), {3'b110, cp[10:6]});
                     name_bytes.insert(name_bytes.size(), {2'b10, cp[5:0]});
                  end
                  3: begin
                     name_bytes.insert(name_bytes.size(), {4'b1110, cp[15:12]});
                     name_bytes.insert(name_bytes.size(), {2'b10, cp[11:6]});
                     name_bytes.insert(name_bytes.size(), {2'b10, cp[5:0]});
                  end
                  default: begin
                     name_bytes.insert(name_bytes.size(), {5'b11110, cp[20:18]});
                     name_bytes.insert(name_bytes.size(), {2'b10, cp[17:12]});
                     name_bytes.insert(name_bytes.size(), {2'b10, cp[11:6]});
                     name_bytes.insert(name_bytes.size(), {2'b10, cp[5:0]});
                  end
               endcase
               // broken sequence: drop the final follow byte
               if (cut) void'(name_bytes.pop_back());
            end
         end
         // sometimes the name stops inside a sequence
         if (name_bytes.size() > 1 && $urandom_range(0, 9) == 0) void'(name_bytes.pop_back());
         foreach (name_bytes[i])
            send_item(name_bytes[i], i == name_bytes.size() - 1, 1'b0, NoPair);
      end
      req_valid <= 1'b0;

      // drain, then wait for anything extra
      while (expected_bigrams.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (mismatch_count == 0)
         $display("utf8_cjk_bigram_extractor_core: match");
      else
         $display("utf8_cjk_bigram_extractor_core: mismatch");
      $finish;
   end

endmodule
